FILE: hdl/hvt_pkg.sv
// ----------------------------------------------------------------------------
// hvt_pkg
// Types and constants shared by the homogeneous vertex transform core.
// ----------------------------------------------------------------------------
`default_nettype none

package hvt_pkg;

  localparam int unsigned VEC_N     = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned PAIR_W    = PROD_W + 1;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned NUM_REGS  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

  typedef logic [DATA_W-1:0]         elem_t;
  typedef elem_t [VEC_N-1:0]         vec_t;
  typedef elem_t [VEC_N-1:0][VEC_N-1:0] mat_t;
  typedef logic [PROD_W-1:0]         prod_t;
  typedef prod_t [VEC_N-1:0][VEC_N-1:0] prod_arr_t;
  typedef logic [PAIR_W-1:0]         pair_t;
  typedef pair_t [VEC_N-1:0][1:0]    pair_arr_t;
  typedef logic [SUM_W-1:0]          sum_t;
  typedef sum_t [VEC_N-1:0]          sum_arr_t;

endpackage

`default_nettype wire

FILE: hdl/hvt_cfg_regs.sv
// ----------------------------------------------------------------------------
// hvt_cfg_regs
// Matrix register file: eight 64-bit registers, identity at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_cfg_regs
  import hvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output mat_t                      mat
);

  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << DATA_W;

  logic [CFG_W-1:0] regs_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_ROW0_COLS01[2:0]] <= ONE_LO;
      regs_r[REG_ROW0_COLS23[2:0]] <= '0;
      regs_r[REG_ROW1_COLS01[2:0]] <= ONE_HI;
      regs_r[REG_ROW1_COLS23[2:0]] <= '0;
      regs_r[REG_ROW2_COLS01[2:0]] <= '0;
      regs_r[REG_ROW2_COLS23[2:0]] <= ONE_LO;
      regs_r[REG_ROW3_COLS01[2:0]] <= '0;
      regs_r[REG_ROW3_COLS23[2:0]] <= ONE_HI;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      regs_r[cfg_index[2:0]] <= cfg_wdata;
    end
  end

  // row r, column c lives in register 2r + c/2, high half for odd c
  always_comb begin
    for (int r = 0; r < VEC_N; r++) begin
      for (int c = 0; c < VEC_N; c++) begin
        mat[r][c] = (c % 2 == 1) ? regs_r[2*r + c/2][CFG_W-1:DATA_W]
                                 : regs_r[2*r + c/2][DATA_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/hvt_mul_array.sv
// ----------------------------------------------------------------------------
// hvt_mul_array
// Input register and sixteen registered 32x32 signed products.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_mul_array
  import hvt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_vld,
  input  wire vec_t      in_vec,
  input  wire mat_t      mat,
  output logic           prod_vld,
  output prod_arr_t      prod
);

  logic      vec_vld_r;
  vec_t      vec_r;
  logic      prod_vld_r;
  prod_arr_t prod_r;
  prod_arr_t prod_nxt;

  always_comb begin
    for (int i = 0; i < VEC_N; i++) begin
      for (int j = 0; j < VEC_N; j++) begin
        prod_nxt[i][j] = $signed(vec_r[i]) * $signed(mat[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vec_vld_r  <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      vec_vld_r  <= in_vld;
      prod_vld_r <= vec_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    vec_r  <= in_vec;
    prod_r <= prod_nxt;
  end

  assign prod_vld = prod_vld_r;
  assign prod     = prod_r;

endmodule

`default_nettype wire

FILE: hdl/hvt_add_tree.sv
// ----------------------------------------------------------------------------
// hvt_add_tree
// Two-level registered adder tree: per column, four products to one sum.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_add_tree
  import hvt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      prod_vld,
  input  wire prod_arr_t prod,
  output logic           sum_vld,
  output sum_arr_t       sum
);

  logic      pair_vld_r;
  pair_arr_t pair_r;
  pair_arr_t pair_nxt;
  logic      sum_vld_r;
  sum_arr_t  sum_r;
  sum_arr_t  sum_nxt;

  always_comb begin
    for (int j = 0; j < VEC_N; j++) begin
      pair_nxt[j][0] = PAIR_W'($signed(prod[0][j])) + PAIR_W'($signed(prod[1][j]));
      pair_nxt[j][1] = PAIR_W'($signed(prod[2][j])) + PAIR_W'($signed(prod[3][j]));
      sum_nxt[j]     = SUM_W'($signed(pair_r[j][0])) + SUM_W'($signed(pair_r[j][1]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_vld_r <= 1'b0;
      sum_vld_r  <= 1'b0;
    end else begin
      pair_vld_r <= prod_vld;
      sum_vld_r  <= pair_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    pair_r <= pair_nxt;
    sum_r  <= sum_nxt;
  end

  assign sum_vld = sum_vld_r;
  assign sum     = sum_r;

endmodule

`default_nettype wire

FILE: hdl/hvt_round_sat.sv
// ----------------------------------------------------------------------------
// hvt_round_sat
// Arithmetic shift by the fraction width, saturation to 32 bits, output word.
// ----------------------------------------------------------------------------
`default_nettype none

module hvt_round_sat
  import hvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     sum_vld,
  input  wire sum_arr_t sum,
  output logic          res_vld,
  output vec_t          res_vec,
  output logic          res_sat
);

  localparam elem_t MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam elem_t MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};

  logic       res_vld_r;
  vec_t       res_vec_r;
  vec_t       res_vec_nxt;
  logic       res_sat_r;
  logic       res_sat_nxt;
  sum_t       shifted;
  logic [SUM_W-DATA_W:0] top_bits;
  logic       clip;

  always_comb begin
    res_sat_nxt = 1'b0;
    shifted     = '0;
    top_bits    = '0;
    clip        = 1'b0;
    for (int j = 0; j < VEC_N; j++) begin
      shifted  = sum_t'($signed(sum[j]) >>> FRAC_BITS);
      top_bits = shifted[SUM_W-1:DATA_W-1];
      clip     = !((&top_bits) || !(|top_bits));
      if (clip) begin
        res_vec_nxt[j] = sum[j][SUM_W-1] ? MIN_VAL : MAX_VAL;
      end else begin
        res_vec_nxt[j] = shifted[DATA_W-1:0];
      end
      res_sat_nxt = res_sat_nxt | clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else begin
      res_vld_r <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    res_vec_r <= res_vec_nxt;
    res_sat_r <= res_sat_nxt;
  end

  assign res_vld = res_vld_r;
  assign res_vec = res_vec_r;
  assign res_sat = res_sat_r;

endmodule

`default_nettype wire

FILE: hdl/homogeneous_vertex_transform_core.sv
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_core
// Row vector (x,y,z,w) times a 4x4 Q16.16 matrix, saturated to 32 bits.
// Throughput: one word per cycle; busy is always low, the receiver cannot stall.
// Stages: input register, 16 multipliers, two adder levels, shift and clip.
// Reset (rst_n low, synchronous) loads the identity and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module homogeneous_vertex_transform_core
  import hvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [31:0]   in_x,
  input  wire logic signed [31:0]   in_y,
  input  wire logic signed [31:0]   in_z,
  input  wire logic signed [31:0]   in_w,
  output logic                      out_valid,
  output logic signed [31:0]        out_x,
  output logic signed [31:0]        out_y,
  output logic signed [31:0]        out_z,
  output logic signed [31:0]        out_w,
  output logic                      out_saturated,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  mat_t      mat;
  vec_t      in_vec;
  logic      prod_vld;
  prod_arr_t prod;
  logic      sum_vld;
  sum_arr_t  sum;
  vec_t      res_vec;

  assign busy   = 1'b0;
  assign in_vec = {elem_t'(in_w), elem_t'(in_z), elem_t'(in_y), elem_t'(in_x)};

  hvt_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mat       (mat)
  );

  hvt_mul_array u_mul_array (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_vec   (in_vec),
    .mat      (mat),
    .prod_vld (prod_vld),
    .prod     (prod)
  );

  hvt_add_tree u_add_tree (
    .clk      (clk),
    .rst_n    (rst_n),
    .prod_vld (prod_vld),
    .prod     (prod),
    .sum_vld  (sum_vld),
    .sum      (sum)
  );

  hvt_round_sat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round_sat (
    .clk     (clk),
    .rst_n   (rst_n),
    .sum_vld (sum_vld),
    .sum     (sum),
    .res_vld (out_valid),
    .res_vec (res_vec),
    .res_sat (out_saturated)
  );

  assign out_x = $signed(res_vec[0]);
  assign out_y = $signed(res_vec[1]);
  assign out_z = $signed(res_vec[2]);
  assign out_w = $signed(res_vec[3]);

endmodule

`default_nettype wire

FILE: verif/homogeneous_vertex_transform_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_core_test
// Streams vertices through the core under several matrix settings and with
// random gaps on the start side. A scoreboard predicts every word from its own
// copy of the matrix (full-width sum, floor shift, clip to 32 bits) and checks
// the output words in order, field by field.
// ----------------------------------------------------------------------------

module homogeneous_vertex_transform_core_test;
  import hvt_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int LATENCY     = 5;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_WORDS = 135;
  localparam int NUM_PHASES  = 8;
  localparam int DRAIN_LIMIT = 1000;
  localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

  typedef logic [CFG_W-1:0] coeff_set_t [NUM_REGS];

  typedef struct packed {
    vec_t comp;
    logic sat;
  } vertex_result_t;

  class vertex_scoreboard;
    logic [CFG_W-1:0] coeff [NUM_REGS];
    vertex_result_t   expected_q [$];
    int mismatches;
    int checked;
    int points;
    int directions;
    int others;
    int sat_words;
    int reg_writes;
    string field_name [VEC_N] = '{"x", "y", "z", "w"};

    function new();
      foreach (coeff[i]) coeff[i] = '0;
      coeff[REG_ROW0_COLS01] = CFG_W'(ONE_FX);
      coeff[REG_ROW1_COLS01] = CFG_W'(ONE_FX) << DATA_W;
      coeff[REG_ROW2_COLS23] = CFG_W'(ONE_FX);
      coeff[REG_ROW3_COLS23] = CFG_W'(ONE_FX) << DATA_W;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      reg_writes++;
      if (idx < NUM_REGS) coeff[idx] = data;
    endfunction

    function logic [DATA_W-1:0] coeff_at(int r, int c);
      return coeff[r * 2 + c / 2][(c % 2) * DATA_W +: DATA_W];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_vector(vec_t v);
      vertex_result_t res;
      logic signed [SUM_W-1:0] acc, a, b, shifted;
      res.sat = 1'b0;
      for (int c = 0; c < VEC_N; c++) begin
        acc = '0;
        for (int r = 0; r < VEC_N; r++) begin
          a = $signed(v[r]);
          b = $signed(coeff_at(r, c));
          acc = acc + a * b;
        end
        shifted = acc >>> FRAC_BITS;
        if (shifted > $signed(SUM_W'(32'h7FFF_FFFF))) begin
          res.comp[c] = 32'h7FFF_FFFF;
          res.sat = 1'b1;
        end else if (shifted < -$signed(SUM_W'(33'h0_8000_0000))) begin
          res.comp[c] = 32'h8000_0000;
          res.sat = 1'b1;
        end else begin
          res.comp[c] = shifted[DATA_W-1:0];
        end
      end
      if (v[3] == ONE_FX) points++;
      else if (v[3] == '0) directions++;
      else others++;
      expected_q.push_back(res);
    endfunction

    function void check_result(vertex_result_t got);
      vertex_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word %h with nothing pending", got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.sat) sat_words++;
      for (int j = 0; j < VEC_N; j++) begin
        if (got.comp[j] !== want.comp[j]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d out_%s: expected %h, got %h",
                     checked, field_name[j], want.comp[j], got.comp[j]);
        end
      end
      if (got.sat !== want.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word %0d out_saturated: expected %b, got %b",
                   checked, want.sat, got.sat);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     start     = 1'b0;
  logic                     busy;
  logic signed [31:0]       in_x      = '0;
  logic signed [31:0]       in_y      = '0;
  logic signed [31:0]       in_z      = '0;
  logic signed [31:0]       in_w      = '0;
  logic                     out_valid;
  logic signed [31:0]       out_x;
  logic signed [31:0]       out_y;
  logic signed [31:0]       out_z;
  logic signed [31:0]       out_w;
  logic                     out_saturated;
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  vertex_scoreboard sb = new();
  int cycle_count = 0;
  int matrix_loads = 0;

  homogeneous_vertex_transform_core #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_x(in_x),
    .in_y(in_y),
    .in_z(in_z),
    .in_w(in_w),
    .out_valid(out_valid),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .out_w(out_w),
    .out_saturated(out_saturated),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("homogeneous_vertex_transform_core_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_vector({in_w, in_z, in_y, in_x});
      if (out_valid) sb.check_result({out_w, out_z, out_y, out_x, out_saturated});
      if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
    end
  end

  task automatic send_vertex(input vec_t v, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      in_x  <= $urandom;
      in_y  <= $urandom;
      in_z  <= $urandom;
      in_w  <= $urandom;
      @(posedge clk);
    end
    start <= 1'b1;
    in_x  <= v[0];
    in_y  <= v[1];
    in_z  <= v[2];
    in_w  <= v[3];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // matrix changes only with the pipeline empty; spare indexes get junk
  task automatic load_matrix(input coeff_set_t m);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
    for (int i = 0; i < 2 ** CFG_IDX_W; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= (i < NUM_REGS) ? m[i] : {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    matrix_loads++;
  endtask

  function automatic logic [DATA_W-1:0] extreme_value();
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return ONE_FX;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] small_value(int bits);
    logic [DATA_W-1:0] raw;
    raw = $urandom;
    return DATA_W'($signed(raw << (DATA_W - bits)) >>> (DATA_W - bits));
  endfunction

  // kind 0 affine, 1 full random, 2 extreme values, 3 projective
  function automatic coeff_set_t random_coeffs(int kind);
    coeff_set_t m;
    logic [DATA_W-1:0] e [VEC_N][VEC_N];
    for (int r = 0; r < VEC_N; r++) begin
      for (int c = 0; c < VEC_N; c++) begin
        case (kind)
          1:       e[r][c] = $urandom;
          2:       e[r][c] = extreme_value();
          default: e[r][c] = small_value(20);
        endcase
      end
      if (kind == 0) e[r][3] = (r == 3) ? ONE_FX : '0;
    end
    for (int r = 0; r < VEC_N; r++) begin
      m[r * 2]     = {e[r][1], e[r][0]};
      m[r * 2 + 1] = {e[r][3], e[r][2]};
    end
    return m;
  endfunction

  function automatic vec_t random_vector();
    vec_t v;
    int kind;
    kind = $urandom_range(9);
    for (int j = 0; j < VEC_N; j++) begin
      if (kind <= 5) v[j] = small_value(24);
      else if (kind <= 7) v[j] = $urandom;
      else if (kind == 8) v[j] = extreme_value();
      else v[j] = small_value(20);
    end
    if (kind <= 5) v[3] = $urandom_range(1) ? ONE_FX : '0;
    return v;
  endfunction

  initial begin
    int idle_pct [4] = '{0, 72, 0, 33};
    int spare;
    coeff_set_t scaled = '{
      {32'h0000_0000, 32'h0000_8000}, {32'hFFFF_C000, 32'h0000_0000},
      {32'h0000_8000, 32'h0001_0000}, {32'h0000_2000, 32'h0000_0000},
      {32'h0000_0000, 32'hFFFF_8000}, {32'h0000_0000, 32'h0000_8000},
      {32'hFFF6_0000, 32'h000A_0000}, {32'h0001_0000, 32'h0003_0000}};
    coeff_set_t all_min = '{default: 64'h8000_0000_8000_0000};
    coeff_set_t all_max = '{default: 64'h7FFF_FFFF_7FFF_FFFF};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity matrix from reset
    send_vertex({ONE_FX, 32'h0003_0000, 32'hFFFD_C000, 32'h0001_8000}, 0);
    send_vertex({32'h0000_0000, 32'hFFFF_0000, 32'h0002_4000, 32'h0007_0000}, 0);
    send_vertex({4{32'h7FFF_FFFF}}, 0);
    send_vertex({4{32'h8000_0000}}, 0);
    send_vertex({4{32'h0000_0000}}, 0);
    send_vertex({4{32'hFFFF_FFFF}}, 0);

    // half scale, translation and a live column 3: floor on odd negatives
    load_matrix(scaled);
    send_vertex({32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 0);
    send_vertex({ONE_FX, 32'hFFFF_FFF9, 32'h0000_0005, 32'hFFFF_FFFD}, 0);
    send_vertex({32'h0000_0000, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF}, 0);
    send_vertex({ONE_FX, 32'h0064_0000, 32'hFFFF_4000, 32'h000C_8000}, 0);

    // most negative coefficients: clip high and low
    load_matrix(all_min);
    send_vertex({4{32'h8000_0000}}, 0);
    send_vertex({4{32'h7FFF_FFFF}}, 0);
    send_vertex({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}, 0);
    send_vertex({4{32'h0000_0000}}, 0);

    load_matrix(all_max);
    send_vertex({4{32'h7FFF_FFFF}}, 0);
    send_vertex({4{32'h8000_0000}}, 0);
    send_vertex({4{32'h0000_0001}}, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_matrix(random_coeffs(p % 4));
      for (int n = 0; n < PHASE_WORDS; n++)
        send_vertex(random_vector(), idle_pct[p % 4]);
    end

    start <= 1'b0;
    spare = 0;
    while (sb.pending() != 0 && spare < DRAIN_LIMIT) begin
      @(posedge clk);
      spare++;
    end
    repeat (LATENCY * 2) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0d expected words never came out", sb.pending());
      sb.mismatches += sb.pending();
    end

    $display("checked %0d words: %0d points, %0d directions, %0d other w, %0d clipped",
             sb.checked, sb.points, sb.directions, sb.others, sb.sat_words);
    $display("%0d matrix loads, %0d register writes incl. ignored indexes, %0d mismatches",
             matrix_loads, sb.reg_writes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("homogeneous_vertex_transform_core_test OK");
    end else begin
      $display("homogeneous_vertex_transform_core_test NOT OK");
    end
    $finish;
  end

endmodule
